// ===== rtl/core/varint_record_parser_unit_assert.svh =====
// Assertion macros shared by the record parser RTL.
`ifndef VARINT_RECORD_PARSER_UNIT_ASSERT_SVH
`define VARINT_RECORD_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VRP_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VRP_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/vrp_pkg.sv =====
// Types and constants shared by the record parser modules.
`timescale 1ns / 1ps
`default_nettype none

package vrp_pkg;

  localparam int COUNT_BITS       = 32;
  localparam int MAX_VARINT_BYTES = 10;
  localparam int VCNT_W           = 4;
  localparam int FIFO_DEPTH       = 4;
  localparam int PTR_W            = 2;
  localparam int CNT_W            = 3;

  localparam logic [63:0] COUNT_MAX = 64'((65'd1 << COUNT_BITS) - 65'd1);

  typedef enum logic [3:0] {
    PH_LEN      = 4'd0,
    PH_ATTR     = 4'd1,
    PH_TS       = 4'd2,
    PH_OFF      = 4'd3,
    PH_KEYLEN   = 4'd4,
    PH_KEYBYTE  = 4'd5,
    PH_VALLEN   = 4'd6,
    PH_VALBYTE  = 4'd7,
    PH_HDRCOUNT = 4'd8,
    PH_HKEYLEN  = 4'd9,
    PH_HKEYBYTE = 4'd10,
    PH_HVALLEN  = 4'd11,
    PH_HVALBYTE = 4'd12
  } phase_t;

  // Result kinds 0..12 share their codes with the phases that produce them.
  localparam logic [3:0] KIND_DONE  = 4'd13;
  localparam logic [3:0] KIND_ERROR = 4'd14;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic [31:0] hdr;
    logic        last;
  } result_t;

  // Up to two results per input beat; v1 only ever comes with v0.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/core/vrp_decode.sv =====
// Record field decoder: parse state and per-beat result generation.
`timescale 1ns / 1ps
`default_nettype none
`include "varint_record_parser_unit_assert.svh"

module vrp_decode (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    data_byte,
  input  wire logic          eob,
  output vrp_pkg::push_t     push
);
  import vrp_pkg::*;

  phase_t                  phase_r, phase_nxt;
  logic [63:0]             acc_r, acc_nxt;
  logic [VCNT_W-1:0]       vcnt_r, vcnt_nxt;
  logic [COUNT_BITS-1:0]   prem_r, prem_nxt;
  logic [COUNT_BITS-1:0]   hrem_r, hrem_nxt;
  logic [31:0]             hctr_r, hctr_nxt;
  logic [31:0]             consumed_r;

  logic [6:0]              shamt_w;
  logic [5:0]              shamt;
  logic [63:0]             raw;
  logic [63:0]             zz;
  logic                    neg;
  logic                    is_hdr;
  logic [31:0]             hdr_idx;
  logic [COUNT_BITS-1:0]   prem_dec;
  logic [COUNT_BITS-1:0]   hrem_dec;
  logic [VCNT_W-1:0]       vcnt_inc;
  logic [31:0]             consumed_inc;

  logic                    f_v;
  logic [3:0]              f_kind;
  logic [63:0]             f_val;
  logic [31:0]             f_hdr;
  logic                    failed;
  logic                    finished;
  logic                    do_after;
  phase_t                  after_p;
  logic                    t_v;
  logic [3:0]              t_kind;
  logic [63:0]             t_val;
  result_t                 f_res;
  result_t                 t_res;

  // Merge the next 7-bit group into the varint and undo zigzag
  assign shamt_w  = {3'b000, vcnt_r} * 7'd7;
  assign shamt    = shamt_w[5:0];
  assign raw      = acc_r | ({57'd0, data_byte[6:0]} << shamt);
  assign zz       = {1'b0, raw[63:1]} ^ {64{raw[0]}};
  assign neg      = zz[63];

  assign is_hdr   = (phase_r == PH_HKEYLEN) || (phase_r == PH_HKEYBYTE) ||
                    (phase_r == PH_HVALLEN) || (phase_r == PH_HVALBYTE);
  assign hdr_idx  = is_hdr ? hctr_r : 32'd0;
  assign prem_dec = prem_r - COUNT_BITS'(1);
  assign hrem_dec = hrem_r - COUNT_BITS'(1);
  assign vcnt_inc = vcnt_r + VCNT_W'(1);
  assign consumed_inc = consumed_r + 32'd1;

  // Decode one beat against the current phase
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    vcnt_nxt  = vcnt_r;
    prem_nxt  = prem_r;
    hrem_nxt  = hrem_r;
    hctr_nxt  = hctr_r;
    f_v       = 1'b0;
    f_kind    = 4'(phase_r);
    f_val     = 64'd0;
    f_hdr     = 32'd0;
    failed    = 1'b0;
    finished  = 1'b0;
    do_after  = 1'b0;
    after_p   = phase_r;

    unique case (phase_r) inside
      PH_ATTR: begin
        f_v       = 1'b1;
        f_val     = {{56{data_byte[7]}}, data_byte};
        phase_nxt = PH_TS;
      end
      PH_KEYBYTE, PH_VALBYTE, PH_HKEYBYTE, PH_HVALBYTE: begin
        f_v      = 1'b1;
        f_val    = {56'd0, data_byte};
        f_hdr    = hdr_idx;
        prem_nxt = prem_dec;
        if (prem_dec == '0) begin
          do_after = 1'b1;
          after_p  = phase_r;
        end
      end
      PH_LEN, PH_TS, PH_OFF, PH_KEYLEN, PH_VALLEN, PH_HDRCOUNT, PH_HKEYLEN,
      PH_HVALLEN: begin
        acc_nxt = raw;
        if (data_byte[7]) begin
          // More groups follow; give up once the varint is too long
          vcnt_nxt = vcnt_inc;
          if (vcnt_inc >= VCNT_W'(MAX_VARINT_BYTES)) begin
            failed = 1'b1;
          end
        end else begin
          acc_nxt  = 64'd0;
          vcnt_nxt = '0;
          if (phase_r == PH_LEN || phase_r == PH_TS || phase_r == PH_OFF) begin
            f_v   = 1'b1;
            f_val = zz;
            phase_nxt = phase_t'(4'(phase_r) + 4'd1);
          end else if (phase_r == PH_HDRCOUNT) begin
            if (raw > COUNT_MAX) begin
              failed = 1'b1;
            end else begin
              f_v      = 1'b1;
              f_val    = raw;
              hrem_nxt = raw[COUNT_BITS-1:0];
              hctr_nxt = 32'd0;
              if (raw == 64'd0) begin
                finished = 1'b1;
              end else begin
                phase_nxt = PH_HKEYLEN;
              end
            end
          end else begin
            // Nullable length: negative means null, zero means empty
            if (!neg && (zz > COUNT_MAX)) begin
              failed = 1'b1;
            end else begin
              f_v   = 1'b1;
              f_val = zz;
              f_hdr = hdr_idx;
              if (neg || (zz == 64'd0)) begin
                do_after = 1'b1;
                after_p  = phase_t'(4'(phase_r) + 4'd1);
              end else begin
                prem_nxt  = zz[COUNT_BITS-1:0];
                phase_nxt = phase_t'(4'(phase_r) + 4'd1);
              end
            end
          end
        end
      end
      default: begin
        failed = 1'b1;
      end
    endcase

    // Advance past a finished nullable item
    if (do_after) begin
      case (after_p)
        PH_KEYBYTE:  phase_nxt = PH_VALLEN;
        PH_VALBYTE:  phase_nxt = PH_HDRCOUNT;
        PH_HKEYBYTE: phase_nxt = PH_HVALLEN;
        default: begin
          hctr_nxt = hctr_r + 32'd1;
          hrem_nxt = hrem_dec;
          if (hrem_dec == '0) begin
            finished = 1'b1;
          end else begin
            phase_nxt = PH_HKEYLEN;
          end
        end
      endcase
    end
  end

  // Closing result: error, done or early end of buffer
  always_comb begin
    t_v    = failed || finished || eob;
    t_kind = KIND_ERROR;
    t_val  = 64'd0;
    if (!failed && finished) begin
      t_kind = KIND_DONE;
      t_val  = {32'd0, consumed_inc};
    end
  end

  // Pack results so a lone result always takes the first slot
  always_comb begin
    f_res      = '{kind: f_kind, value: f_val, hdr: f_hdr, last: !t_v};
    t_res      = '{kind: t_kind, value: t_val, hdr: 32'd0, last: 1'b1};
    push.v0    = step && (f_v || t_v);
    push.v1    = step && f_v && t_v;
    push.r0    = f_v ? f_res : t_res;
    push.r1    = t_res;
  end

  // Commit state; restart after any closing result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEN;
      acc_r      <= 64'd0;
      vcnt_r     <= '0;
      prem_r     <= '0;
      hrem_r     <= '0;
      hctr_r     <= 32'd0;
      consumed_r <= 32'd0;
    end else if (step) begin
      if (t_v) begin
        phase_r    <= PH_LEN;
        acc_r      <= 64'd0;
        vcnt_r     <= '0;
        prem_r     <= '0;
        hrem_r     <= '0;
        hctr_r     <= 32'd0;
        consumed_r <= 32'd0;
      end else begin
        phase_r    <= phase_nxt;
        acc_r      <= acc_nxt;
        vcnt_r     <= vcnt_nxt;
        prem_r     <= prem_nxt;
        hrem_r     <= hrem_nxt;
        hctr_r     <= hctr_nxt;
        consumed_r <= consumed_inc;
      end
    end
  end

  `VRP_ASSERT_NOW(a_vcnt_bound, clk, rst_n, 1'b1, vcnt_r < VCNT_W'(MAX_VARINT_BYTES), "varint group count out of range")
  `VRP_ASSERT_NOW(a_second_is_last, clk, rst_n, push.v1, push.r1.last && !push.r0.last, "two-result beat marks last wrongly")

endmodule

`default_nettype wire

// ===== rtl/core/vrp_out_fifo.sv =====
// Result queue between the decoder and the output channel.
`timescale 1ns / 1ps
`default_nettype none
`include "varint_record_parser_unit_assert.svh"

module vrp_out_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire vrp_pkg::push_t  push,
  input  wire logic            pop,
  output vrp_pkg::result_t     head,
  output logic                 not_empty,
  output logic                 has_room
);
  import vrp_pkg::*;

  result_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [PTR_W-1:0]    wr_ptr_p1;

  assign wr_ptr_p1  = wr_ptr_r + PTR_W'(1);
  assign head       = mem[rd_ptr_r];
  assign not_empty  = (count_r != '0);
  // Room for the two results one beat can produce
  assign has_room   = (count_r <= CNT_W'(FIFO_DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.v0) + PTR_W'(push.v1);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign count_nxt  = count_r + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop);

  // Store incoming results
  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.v1) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `VRP_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(FIFO_DEPTH), "result queue overflow")
  `VRP_ASSERT_NOW(a_push_room, clk, rst_n, push.v0, has_room, "push into a full result queue")
  `VRP_ASSERT_NEXT(a_pop_only, clk, rst_n, pop && !push.v0, count_r == $past(count_r) - CNT_W'(1), "pop did not drain one entry")

endmodule

`default_nettype wire

// ===== rtl/core/varint_record_parser_unit.sv =====
// Results of an accepted byte are registered in a 4-entry result queue.
// Throughput: one byte per cycle while in_ready is high; a byte that yields
// two results (a field plus done or error) is queued as two output beats.
// in_ready drops while the result queue holds three or more results.
// Reset: rst_n is synchronous, active low; parse state and queue clear.
`timescale 1ns / 1ps
`default_nettype none

module varint_record_parser_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_end_of_buffer,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              out_kind,
  output logic signed [63:0]      out_field_value,
  output logic [31:0]             out_header_number,
  output logic                    out_last
);
  import vrp_pkg::*;

  push_t    push;
  result_t  head;
  logic     step;
  logic     pop;
  logic     has_room;
  logic     not_empty;

  // Accept a byte whenever the queue can take its results
  assign in_ready  = has_room;
  assign step      = in_valid && has_room;
  assign out_valid = not_empty;
  assign pop       = not_empty && out_ready;

  vrp_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_data_byte),
    .eob       (in_end_of_buffer),
    .push      (push)
  );

  vrp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .has_room  (has_room)
  );

  // Drive the result channel from the queue head
  assign out_kind          = head.kind;
  assign out_field_value   = head.value;
  assign out_header_number = head.hdr;
  assign out_last          = head.last;

endmodule

`default_nettype wire

// ===== test/varint_record_parser_unit_test.sv =====
// Self-checking testbench for the zigzag varint log record parser.
`timescale 1ns / 1ps

module varint_record_parser_unit_test;
  import vrp_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_kind;
  logic signed [63:0] out_field_value;
  logic [31:0] out_header_number;
  logic        out_last;

  varint_record_parser_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_buffer  (in_end_of_buffer),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_field_value   (out_field_value),
    .out_header_number (out_header_number),
    .out_last          (out_last)
  );

  always #5 clk = ~clk;

  // Parser state mirrored for prediction
  phase_t      rec_phase;
  logic [63:0] vint_acc;
  int unsigned vint_bytes;
  logic [63:0] payload_left;
  logic [63:0] headers_left;
  logic [63:0] header_idx;
  logic [31:0] consumed_bytes;

  result_t     step_results[$];
  result_t     expected_results[$];
  logic [7:0]  rec_bytes[$];
  int          burst_left = 0;
  int          bytes_sent = 0;
  int          mismatches = 0;
  logic [15:0] stall_tick = 16'd0;

  function automatic void clear_parse_state();
    rec_phase      = PH_LEN;
    vint_acc       = 64'd0;
    vint_bytes     = 0;
    payload_left   = 64'd0;
    headers_left   = 64'd0;
    header_idx     = 64'd0;
    consumed_bytes = 32'd0;
  endfunction

  function automatic void add_result(logic [3:0] kind, logic [63:0] value, logic [31:0] hdr);
    result_t r;
    r.kind  = kind;
    r.value = value;
    r.hdr   = hdr;
    r.last  = 1'b0;
    step_results.insert(step_results.size(), r);
  endfunction

  // Advance past a finished nullable item; return 1 when the record is complete
  function automatic bit close_item(phase_t pay);
    case (pay)
      PH_KEYBYTE: begin
        rec_phase = PH_VALLEN;
        return 1'b0;
      end
      PH_VALBYTE: begin
        rec_phase = PH_HDRCOUNT;
        return 1'b0;
      end
      PH_HKEYBYTE: begin
        rec_phase = PH_HVALLEN;
        return 1'b0;
      end
      default: begin
        header_idx++;
        headers_left--;
        if (headers_left == 64'd0) return 1'b1;
        rec_phase = PH_HKEYLEN;
        return 1'b0;
      end
    endcase
  endfunction

  // Work out the results of one accepted byte and queue them
  function automatic void decode_byte(logic [7:0] data, logic eob);
    bit          finished;
    bit          failed;
    bit          neg;
    logic [31:0] hnum;
    logic [63:0] raw;
    logic [63:0] zz;
    phase_t      pay;
    finished = 1'b0;
    failed   = 1'b0;
    hnum = (rec_phase >= PH_HKEYLEN && rec_phase <= PH_HVALBYTE) ? header_idx[31:0] : 32'd0;
    consumed_bytes++;

    if (rec_phase == PH_ATTR) begin
      add_result(4'(PH_ATTR), {{56{data[7]}}, data}, 32'd0);
      rec_phase = PH_TS;
    end else if (rec_phase == PH_KEYBYTE || rec_phase == PH_VALBYTE ||
                 rec_phase == PH_HKEYBYTE || rec_phase == PH_HVALBYTE) begin
      add_result(4'(rec_phase), {56'd0, data}, hnum);
      payload_left--;
      if (payload_left == 64'd0) finished = close_item(rec_phase);
    end else begin
      vint_acc |= 64'(data[6:0]) << ((7 * vint_bytes) & 63);
      if (data[7]) begin
        vint_bytes++;
        if (vint_bytes >= MAX_VARINT_BYTES) failed = 1'b1;
      end else begin
        raw = vint_acc;
        zz  = (raw >> 1) ^ {64{raw[0]}};
        neg = zz[63];
        vint_acc   = 64'd0;
        vint_bytes = 0;
        case (rec_phase)
          PH_LEN: begin
            add_result(4'(PH_LEN), zz, 32'd0);
            rec_phase = PH_ATTR;
          end
          PH_TS: begin
            add_result(4'(PH_TS), zz, 32'd0);
            rec_phase = PH_OFF;
          end
          PH_OFF: begin
            add_result(4'(PH_OFF), zz, 32'd0);
            rec_phase = PH_KEYLEN;
          end
          PH_HDRCOUNT: begin
            if (raw > COUNT_MAX) begin
              failed = 1'b1;
            end else begin
              add_result(4'(PH_HDRCOUNT), raw, 32'd0);
              headers_left = raw;
              header_idx   = 64'd0;
              if (raw == 64'd0) finished = 1'b1;
              else rec_phase = PH_HKEYLEN;
            end
          end
          default: begin
            pay = phase_t'(rec_phase + 4'd1);
            if (!neg && zz > COUNT_MAX) begin
              failed = 1'b1;
            end else begin
              add_result(4'(rec_phase), zz, hnum);
              if (neg || zz == 64'd0) begin
                finished = close_item(pay);
              end else begin
                payload_left = zz;
                rec_phase    = pay;
              end
            end
          end
        endcase
      end
    end

    if (failed || (!finished && eob)) begin
      add_result(KIND_ERROR, 64'd0, 32'd0);
      clear_parse_state();
    end else if (finished) begin
      add_result(KIND_DONE, {32'd0, consumed_bytes}, 32'd0);
      clear_parse_state();
    end

    // Flag the final result of this beat and move all of them to the expected queue
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) expected_results.insert(expected_results.size(), step_results[i]);
    step_results.delete();
  endfunction

  // Record encoding helpers
  function automatic void put_byte(logic [7:0] b);
    rec_bytes.insert(rec_bytes.size(), b);
  endfunction

  function automatic void put_uvarint(logic [63:0] v);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 64'd0) b[7] = 1'b1;
      put_byte(b);
    end while (v != 64'd0);
  endfunction

  function automatic void put_zigzag(logic [63:0] s);
    put_uvarint({s[62:0], 1'b0} ^ {64{s[63]}});
  endfunction

  // Length plus payload; only positive lengths carry payload
  function automatic void put_item(logic [63:0] len);
    put_zigzag(len);
    if (!len[63] && len != 64'd0) begin
      repeat (int'(len)) put_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void begin_record(logic [63:0] len, logic [7:0] attr,
                                       logic [63:0] ts, logic [63:0] offs);
    rec_bytes.delete();
    put_zigzag(len);
    put_byte(attr);
    put_zigzag(ts);
    put_zigzag(offs);
  endfunction

  function automatic logic [63:0] pick_field();
    case ($urandom_range(0, 5))
      0, 1: return 64'(longint'($urandom_range(0, 400)) - 200);
      2: return {$urandom, $urandom};
      3: return 64'h8000_0000_0000_0000;
      4: return 64'h7FFF_FFFF_FFFF_FFFF;
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  function automatic logic [63:0] pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 64'hFFFF_FFFF_FFFF_FFFF;
    if (r < 3) return {1'b1, 31'($urandom), $urandom};
    if (r < 6) return 64'd0;
    return 64'($urandom_range(1, 6));
  endfunction

  function automatic void build_random_record();
    int n;
    begin_record(pick_field(), 8'($urandom_range(0, 255)), pick_field(), pick_field());
    put_item(pick_len());
    put_item(pick_len());
    n = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 4);
    put_uvarint(64'(n));
    repeat (n) begin
      put_item(pick_len());
      put_item(pick_len());
    end
  endfunction

  // Send one beat; sender works in bursts with random gaps
  task automatic send_byte(input logic [7:0] data, input logic eob);
    int   gap;
    logic taken;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= data;
    in_end_of_buffer <= eob;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    burst_left--;
    bytes_sent++;
    decode_byte(data, eob);
  endtask

  task automatic send_record(input logic eob_last);
    int n;
    n = rec_bytes.size();
    for (int i = 0; i < n; i++) send_byte(rec_bytes[i], eob_last && (i == n - 1));
    rec_bytes.delete();
  endtask

  // Receiver: cycle through always ready, coin flip, one in four, and mostly ready
  always @(posedge clk) begin
    stall_tick <= stall_tick + 16'd1;
    case (stall_tick[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (stall_tick[1:0] == 2'd0);
      default: out_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Compare each accepted result beat with the oldest expectation
  always @(negedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d value %h", $time, out_kind, out_field_value);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_kind !== want.kind) begin
          $display("%0t: kind expected %0d got %0d", $time, want.kind, out_kind);
          mismatches++;
        end
        if (out_field_value !== want.value) begin
          $display("%0t: field_value expected %h got %h", $time, want.value, out_field_value);
          mismatches++;
        end
        if (out_header_number !== want.hdr) begin
          $display("%0t: header_number expected %0d got %0d", $time, want.hdr,
                   out_header_number);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  task automatic test_minimal_record();
    // All-zero record, done on a byte that also ends the buffer
    begin_record(64'd0, 8'h00, 64'd0, 64'd0);
    put_item(64'd0);
    put_item(64'd0);
    put_uvarint(64'd0);
    send_record(1'b1);
    // Key with payload, null value, no buffer end
    begin_record(64'd5, 8'h7F, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    put_item(64'd2);
    put_item(64'hFFFF_FFFF_FFFF_FFFF);
    put_uvarint(64'd0);
    send_record(1'b0);
  endtask

  task automatic test_headers();
    begin_record(64'd1, 8'h01, 64'd3, 64'd4);
    put_item(64'd0);
    put_item(64'd1);
    put_uvarint(64'd3);
    put_item(64'd1);
    put_item(64'hFFFF_FFFF_FFFF_FFFB);
    put_item(64'd0);
    put_item(64'd2);
    put_item(64'd1);
    put_item(64'hFFFF_FFFF_FFFF_FFFF);
    send_record(1'b1);
  endtask

  task automatic test_field_extremes();
    // Largest and smallest signed values, ten-byte varints, null by most negative length
    begin_record(64'h7FFF_FFFF_FFFF_FFFF, 8'h80, 64'h8000_0000_0000_0000,
                 64'h7FFF_FFFF_FFFF_FFFF);
    put_item(64'h8000_0000_0000_0000);
    put_byte(8'h02);
    put_byte(8'hFF);
    put_uvarint(64'd1);
    put_item(64'h8000_0000_0000_0000);
    put_byte(8'h02);
    put_byte(8'h00);
    send_record(1'b0);
    begin_record(64'h8000_0000_0000_0000, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    put_item(64'd0);
    put_item(64'd0);
    put_uvarint(64'd0);
    send_record(1'b1);
  endtask

  task automatic test_overlong_varint();
    // Continuation still set on the tenth byte of the record length
    rec_bytes.delete();
    repeat (10) put_byte(8'hFF);
    send_record(1'b0);
    // Same inside the timestamp
    rec_bytes.delete();
    put_byte(8'h00);
    put_byte(8'h00);
    repeat (10) put_byte(8'h80);
    send_record(1'b0);
  endtask

  task automatic test_count_too_large();
    // Key length one above the counter range
    begin_record(64'd0, 8'h00, 64'd0, 64'd0);
    put_zigzag(64'h1_0000_0000);
    send_record(1'b0);
    // Header count one above the range, then the largest raw count
    begin_record(64'd0, 8'h00, 64'd0, 64'd0);
    put_item(64'd0);
    put_item(64'd0);
    put_uvarint(64'h1_0000_0000);
    send_record(1'b0);
    begin_record(64'd0, 8'h00, 64'd0, 64'd0);
    put_item(64'd0);
    put_item(64'd0);
    put_uvarint(64'hFFFF_FFFF_FFFF_FFFF);
    send_record(1'b0);
    // Header value length too large
    begin_record(64'd0, 8'h00, 64'd0, 64'd0);
    put_item(64'd0);
    put_item(64'd0);
    put_uvarint(64'd1);
    put_item(64'd0);
    put_zigzag(64'h1_0000_0000);
    send_record(1'b0);
  endtask

  task automatic test_early_end();
    // Buffer ends on the attribute byte
    begin_record(64'd3, 8'h10, 64'd0, 64'd0);
    void'(rec_bytes.pop_back());
    void'(rec_bytes.pop_back());
    send_record(1'b1);
    // Buffer ends inside a multi-byte varint
    rec_bytes.delete();
    put_byte(8'h80);
    send_record(1'b1);
    // Buffer ends on a key payload byte
    begin_record(64'd0, 8'h00, 64'd0, 64'd0);
    put_item(64'd3);
    void'(rec_bytes.pop_back());
    send_record(1'b1);
  endtask

  task automatic test_random_records();
    int start;
    int pick;
    int pos;
    start = bytes_sent;
    while (bytes_sent - start < 2000) begin
      pick = $urandom_range(0, 99);
      build_random_record();
      if (pick < 70) begin
        send_record(1'($urandom_range(0, 1)));
      end else if (pick < 82) begin
        // Cut the record short and end the buffer there
        pos = $urandom_range(0, rec_bytes.size() - 1);
        while (rec_bytes.size() > pos + 1) void'(rec_bytes.pop_back());
        send_record(1'b1);
      end else if (pick < 94) begin
        // Damage one byte or splice in a run of continuation bytes
        pos = $urandom_range(0, rec_bytes.size() - 1);
        if ($urandom_range(0, 3) == 0) begin
          repeat (10) rec_bytes.insert(pos, 8'hFF);
        end else begin
          rec_bytes[pos] = 8'($urandom_range(0, 255));
        end
        send_record(1'b1);
      end else begin
        // Raw noise with scattered buffer ends, closed by one
        rec_bytes.delete();
        pos = $urandom_range(1, 16);
        for (int i = 0; i < pos; i++) begin
          send_byte(8'($urandom_range(0, 255)), (i == pos - 1) || ($urandom_range(0, 4) == 0));
        end
      end
    end
  endtask

  initial begin
    clear_parse_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_minimal_record();
    test_headers();
    test_field_extremes();
    test_overlong_varint();
    test_count_too_large();
    test_early_end();
    test_random_records();
    in_valid <= 1'b0;
    // Drain outstanding results, then allow stray beats to show up
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/vrp_pkg.sv
rtl/core/vrp_decode.sv
rtl/core/vrp_out_fifo.sv
rtl/core/varint_record_parser_unit.sv
test/varint_record_parser_unit_test.sv
